// ----- src/wrle_pkg.sv -----
package wrle_pkg;

    // Default sizes of the sequence table and the phase cap.
    localparam int DEF_MAX_PHASES = 2048;
    localparam int DEF_ROWS_PER_SEQUENCE = 64;
    localparam int DEF_GRAY_LEVELS = 16;

    // Row byte layout: code in bits 7-6, last flag in bit 5, count in bits 4-0.
    localparam int CODE_SHIFT = 6;
    localparam int LAST_BIT = 5;
    localparam int COUNT_W = 5;

    // Fixed field widths of the channels.
    localparam int ADDR_W = 14;
    localparam int BYTE_W = 8;
    localparam int LEVEL_W = 4;
    localparam int ROW_FIELD_W = 6;
    localparam int PHASE_W = 12;

    // Command queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_WALK = 2'd1,
        K_BAD  = 2'd2
    } t_kind;

    // For K_LOAD, addr is the byte address; for K_WALK, it is the address of
    // the first row to read and row is that row's index within the sequence.
    typedef struct packed {
        t_kind                    kind;
        logic [ADDR_W-1:0]        addr;
        logic [BYTE_W-1:0]        data;
        logic [ROW_FIELD_W-1:0]   row;
    } t_cmd;

    // Reduces a level modulo the number of gray levels by repeated subtraction.
    function automatic logic [LEVEL_W-1:0] level_mod(input logic [LEVEL_W-1:0] value,
                                                     input logic [LEVEL_W:0] levels);
        logic [LEVEL_W-1:0] r;
        r = value;
        for (int i = 0; i < 8; i++) begin
            if ({1'b0, r} >= levels) begin
                r = r - levels[LEVEL_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ----- src/wrle_if.sv -----
interface wrle_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [wrle_pkg::ADDR_W-1:0]          load_address;
    logic [wrle_pkg::BYTE_W-1:0]          load_byte;
    logic [wrle_pkg::LEVEL_W-1:0]         from_level;
    logic [wrle_pkg::LEVEL_W-1:0]         to_level;
    logic [wrle_pkg::ROW_FIELD_W-1:0]     start_row;

    modport source (
        output valid, action, load_address, load_byte, from_level, to_level, start_row,
        input  ready
    );
    modport sink (
        input  valid, action, load_address, load_byte, from_level, to_level, start_row,
        output ready
    );
endinterface

interface wrle_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           drive_code;
    logic [wrle_pkg::COUNT_W-1:0]         run_length;
    logic [wrle_pkg::PHASE_W-1:0]         phase_start;
    logic [1:0]                           status;
    logic                                 last;

    modport source (
        output valid, drive_code, run_length, phase_start, status, last,
        input  ready
    );
    modport sink (
        input  valid, drive_code, run_length, phase_start, status, last,
        output ready
    );
endinterface

// ----- src/wrle_front.sv -----
module wrle_front #(
    parameter int ROWS_PER_SEQUENCE = wrle_pkg::DEF_ROWS_PER_SEQUENCE,
    parameter int GRAY_LEVELS = wrle_pkg::DEF_GRAY_LEVELS
) (
    wrle_in_if.sink         i_in,
    output logic            o_push_valid,
    output wrle_pkg::t_cmd  o_push_cmd,
    input  logic            i_push_ready
);

    localparam int TableDepth = GRAY_LEVELS * GRAY_LEVELS * ROWS_PER_SEQUENCE;

    logic [wrle_pkg::LEVEL_W-1:0] from_m;
    logic [wrle_pkg::LEVEL_W-1:0] to_m;
    logic [wrle_pkg::ADDR_W-1:0]  pair;
    logic [wrle_pkg::ADDR_W-1:0]  walk_addr;
    logic                         load_in_range;
    logic                         row_bad;

    assign from_m = wrle_pkg::level_mod(i_in.from_level, (wrle_pkg::LEVEL_W+1)'(GRAY_LEVELS));
    assign to_m   = wrle_pkg::level_mod(i_in.to_level, (wrle_pkg::LEVEL_W+1)'(GRAY_LEVELS));

    assign pair = wrle_pkg::ADDR_W'(from_m) * wrle_pkg::ADDR_W'(GRAY_LEVELS)
                + wrle_pkg::ADDR_W'(to_m);
    assign walk_addr = pair * wrle_pkg::ADDR_W'(ROWS_PER_SEQUENCE)
                     + wrle_pkg::ADDR_W'(i_in.start_row);

    assign load_in_range = (wrle_pkg::ADDR_W+1)'(i_in.load_address)
                         < (wrle_pkg::ADDR_W+1)'(TableDepth);
    assign row_bad = (wrle_pkg::ROW_FIELD_W+1)'(i_in.start_row)
                   >= (wrle_pkg::ROW_FIELD_W+1)'(ROWS_PER_SEQUENCE);

    // A load beyond the table is accepted and dropped here.
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid && (i_in.action || load_in_range);

    always_comb begin
        o_push_cmd.data = i_in.load_byte;
        o_push_cmd.row  = i_in.start_row;
        if (!i_in.action) begin
            o_push_cmd.kind = wrle_pkg::K_LOAD;
            o_push_cmd.addr = i_in.load_address;
        end else if (row_bad) begin
            o_push_cmd.kind = wrle_pkg::K_BAD;
            o_push_cmd.addr = walk_addr;
        end else begin
            o_push_cmd.kind = wrle_pkg::K_WALK;
            o_push_cmd.addr = walk_addr;
        end
    end

endmodule

// ----- src/wrle_queue.sv -----
module wrle_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  wrle_pkg::t_cmd  i_push_cmd,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output wrle_pkg::t_cmd  o_pop_cmd,
    input  logic            i_pop
);

    wrle_pkg::t_cmd              r_mem [wrle_pkg::QUEUE_DEPTH];
    logic [wrle_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [wrle_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [wrle_pkg::QPTR_W:0]   r_count;
    logic                        push;
    logic                        pop;

    assign o_push_ready = r_count != (wrle_pkg::QPTR_W+1)'(wrle_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- src/wrle_back.sv -----
module wrle_back #(
    parameter int MAX_PHASES = wrle_pkg::DEF_MAX_PHASES,
    parameter int ROWS_PER_SEQUENCE = wrle_pkg::DEF_ROWS_PER_SEQUENCE,
    parameter int GRAY_LEVELS = wrle_pkg::DEF_GRAY_LEVELS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  wrle_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    wrle_out_if.source      o_out
);

    localparam int TableDepth = GRAY_LEVELS * GRAY_LEVELS * ROWS_PER_SEQUENCE;
    localparam int AddrW = $clog2(TableDepth);
    localparam int RowW = $clog2(ROWS_PER_SEQUENCE);
    localparam int PhW = wrle_pkg::PHASE_W;
    localparam int CntW = wrle_pkg::COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state                     r_state;
    logic [AddrW-1:0]           r_addr;
    logic [RowW-1:0]            r_row;
    logic [PhW-1:0]             r_total;
    logic [wrle_pkg::BYTE_W-1:0] r_rd_data;
    logic [wrle_pkg::BYTE_W-1:0] r_table [TableDepth];

    logic                       r_out_valid;
    logic [1:0]                 r_code;
    logic [CntW-1:0]            r_run;
    logic [PhW-1:0]             r_phase;
    wrle_pkg::t_status          r_status;
    logic                       r_last;

    logic                       out_free;
    logic [CntW-1:0]            count;
    logic [PhW-1:0]             remaining;
    logic [CntW-1:0]            run;
    logic                       is_empty;
    logic                       row_end;
    logic                       finish;
    logic                       step;
    logic                       load_out;
    logic                       rd_en;
    logic [AddrW-1:0]           rd_addr;
    logic                       wr_en;

    assign out_free  = !r_out_valid || o_out.ready;
    assign count     = r_rd_data[CntW-1:0];
    assign remaining = PhW'(MAX_PHASES) - r_total;
    assign run       = (PhW'(count) > remaining) ? remaining[CntW-1:0] : count;
    assign is_empty  = (r_rd_data == '0) && (r_total == '0);
    assign row_end   = r_row == RowW'(ROWS_PER_SEQUENCE - 1);
    assign finish    = is_empty || r_rd_data[wrle_pkg::LAST_BIT] || row_end;
    assign step      = (r_state == S_WALK) && out_free;

    // An out-of-range start needs the output register; loads and walk starts do not.
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid
                     && ((i_cmd.kind != wrle_pkg::K_BAD) || out_free);
    assign wr_en = o_cmd_pop && (i_cmd.kind == wrle_pkg::K_LOAD);
    assign load_out = (o_cmd_pop && (i_cmd.kind == wrle_pkg::K_BAD)) || step;

    // The next row is fetched while the current one is evaluated, so a walk
    // moves one row per cycle; a stall leaves the read data in place.
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_en   = o_cmd_pop && (i_cmd.kind == wrle_pkg::K_WALK);
            rd_addr = i_cmd.addr[AddrW-1:0];
        end else begin
            rd_en   = step && !finish;
            rd_addr = r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[i_cmd.addr[AddrW-1:0]] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        unique case (i_cmd.kind)
                            wrle_pkg::K_BAD: begin
                                r_code      <= '0;
                                r_run       <= '0;
                                r_phase     <= '0;
                                r_status    <= wrle_pkg::ST_MALFORMED;
                                r_last      <= 1'b1;
                            end
                            wrle_pkg::K_WALK: begin
                                r_addr  <= i_cmd.addr[AddrW-1:0];
                                r_row   <= i_cmd.row[RowW-1:0];
                                r_total <= '0;
                                r_state <= S_WALK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (step) begin
                        r_last      <= finish;
                        if (is_empty) begin
                            r_code   <= '0;
                            r_run    <= '0;
                            r_phase  <= '0;
                            r_status <= wrle_pkg::ST_EMPTY;
                        end else begin
                            r_code  <= r_rd_data[wrle_pkg::CODE_SHIFT +: 2];
                            r_run   <= run;
                            r_phase <= r_total;
                            if (!r_rd_data[wrle_pkg::LAST_BIT] && row_end) begin
                                r_status <= wrle_pkg::ST_MALFORMED;
                            end else begin
                                r_status <= wrle_pkg::ST_OK;
                            end
                        end
                        if (finish) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= r_addr + 1'b1;
                            r_row   <= r_row + 1'b1;
                            r_total <= r_total + PhW'(run);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drive_code  = r_code;
    assign o_out.run_length  = r_run;
    assign o_out.phase_start = r_phase;
    assign o_out.status      = r_status;
    assign o_out.last        = r_last;

endmodule

// ----- src/waveform_run_length_expander.sv -----
// Load item: the item passes the command queue, then the back end writes the table byte.
// Expand item: the first row read is registered, then evaluated into the output register;
// after that one result per cycle (one table row read per cycle) while the output is not
// stalled; a four-entry command queue keeps accepting meanwhile until it is full.
// Reset (i_rst_n low, synchronous) empties the queue and the output register; the
// table keeps no reset value and must be written before it is read.
module waveform_run_length_expander #(
    parameter int MAX_PHASES = wrle_pkg::DEF_MAX_PHASES,
    parameter int ROWS_PER_SEQUENCE = wrle_pkg::DEF_ROWS_PER_SEQUENCE,
    parameter int GRAY_LEVELS = wrle_pkg::DEF_GRAY_LEVELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrle_in_if.sink     i_in,
    wrle_out_if.source  o_out
);

    logic           push_valid;
    wrle_pkg::t_cmd push_cmd;
    logic           push_ready;
    logic           pop_valid;
    wrle_pkg::t_cmd pop_cmd;
    logic           pop;

    wrle_front #(
        .ROWS_PER_SEQUENCE (ROWS_PER_SEQUENCE),
        .GRAY_LEVELS       (GRAY_LEVELS)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    wrle_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    wrle_back #(
        .MAX_PHASES        (MAX_PHASES),
        .ROWS_PER_SEQUENCE (ROWS_PER_SEQUENCE),
        .GRAY_LEVELS       (GRAY_LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop),
        .o_out       (o_out)
    );

endmodule

// ----- src/wrle_checker.sv -----
module wrle_checker #(
    parameter int MaxPhases = wrle_pkg::DEF_MAX_PHASES
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [1:0]                    i_drive_code,
    input logic [wrle_pkg::COUNT_W-1:0]  i_run_length,
    input logic [wrle_pkg::PHASE_W-1:0]  i_phase_start,
    input logic [1:0]                    i_status,
    input logic                          i_last
);

    // A result that waits keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_drive_code) && $stable(i_run_length)
            && $stable(i_phase_start) && $stable(i_status) && $stable(i_last))
        else $error("result changed while stalled");

    // An empty sequence ends the walk and carries no run.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == wrle_pkg::ST_EMPTY) |->
            i_last && (i_drive_code == '0) && (i_run_length == '0) && (i_phase_start == '0))
        else $error("empty status with nonzero fields");

    a_malformed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == wrle_pkg::ST_MALFORMED) |-> i_last)
        else $error("malformed status without last");

    // Clipping keeps every run within the phase cap.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((wrle_pkg::PHASE_W+1)'(i_phase_start) + (wrle_pkg::PHASE_W+1)'(i_run_length))
            <= (wrle_pkg::PHASE_W+1)'(MaxPhases))
        else $error("run exceeds phase cap");

endmodule

bind waveform_run_length_expander wrle_checker #(
    .MaxPhases (MAX_PHASES)
) u_wrle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_drive_code  (o_out.drive_code),
    .i_run_length  (o_out.run_length),
    .i_phase_start (o_out.phase_start),
    .i_status      (o_out.status),
    .i_last        (o_out.last)
);

// ----- dv/wrle_run_checker.sv -----
`timescale 1ns / 1ps
module wrle_run_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    wrle_in_if   i_cmd,
    wrle_out_if  i_runs,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int TABLE_DEPTH = wrle_pkg::DEF_GRAY_LEVELS * wrle_pkg::DEF_GRAY_LEVELS
                               * wrle_pkg::DEF_ROWS_PER_SEQUENCE;

    typedef struct packed {
        logic [1:0]                   code;
        logic [wrle_pkg::COUNT_W-1:0] run;
        logic [wrle_pkg::PHASE_W-1:0] phase;
        logic [1:0]                   status;
        logic                         last;
    } t_run;

    logic [wrle_pkg::BYTE_W-1:0] row_image [TABLE_DEPTH];
    t_run                        expected_runs [$];
    int                          fail_total;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            row_image[i] = '0;
        end
    end

    function automatic void add_run(input logic [1:0] code, input int run, input int phase,
                                    input wrle_pkg::t_status status, input logic last);
        t_run r;
        r.code   = code;
        r.run    = wrle_pkg::COUNT_W'(run);
        r.phase  = wrle_pkg::PHASE_W'(phase);
        r.status = status;
        r.last   = last;
        expected_runs.push_back(r);
    endfunction

    // Walks one transition sequence; one run per row read, or one for a bad start row.
    function automatic void expand_sequence(input logic [wrle_pkg::LEVEL_W-1:0] from_l,
                                            input logic [wrle_pkg::LEVEL_W-1:0] to_l,
                                            input logic [wrle_pkg::ROW_FIELD_W-1:0] first_row);
        int                          from_i;
        int                          to_i;
        int                          row;
        int                          base;
        int                          total;
        int                          run;
        bit                          done;
        logic [wrle_pkg::BYTE_W-1:0] row_byte;
        from_i = int'(from_l) % wrle_pkg::DEF_GRAY_LEVELS;
        to_i   = int'(to_l) % wrle_pkg::DEF_GRAY_LEVELS;
        row    = int'(first_row);
        if (row >= wrle_pkg::DEF_ROWS_PER_SEQUENCE) begin
            add_run(2'd0, 0, 0, wrle_pkg::ST_MALFORMED, 1'b1);
            return;
        end
        base  = (from_i * wrle_pkg::DEF_GRAY_LEVELS + to_i) * wrle_pkg::DEF_ROWS_PER_SEQUENCE;
        total = 0;
        done  = 1'b0;
        while (!done) begin
            row_byte = row_image[base + row];
            if (row_byte == '0 && total == 0) begin
                add_run(2'd0, 0, 0, wrle_pkg::ST_EMPTY, 1'b1);
                done = 1'b1;
            end else begin
                run = int'(row_byte[wrle_pkg::COUNT_W-1:0]);
                if (run > wrle_pkg::DEF_MAX_PHASES - total) begin
                    run = wrle_pkg::DEF_MAX_PHASES - total;
                end
                if (row_byte[wrle_pkg::LAST_BIT]) begin
                    add_run(row_byte[wrle_pkg::CODE_SHIFT +: 2], run, total,
                            wrle_pkg::ST_OK, 1'b1);
                    done = 1'b1;
                end else if (row >= wrle_pkg::DEF_ROWS_PER_SEQUENCE - 1) begin
                    // The sequence ran off its final row without a last flag.
                    add_run(row_byte[wrle_pkg::CODE_SHIFT +: 2], run, total,
                            wrle_pkg::ST_MALFORMED, 1'b1);
                    done = 1'b1;
                end else begin
                    add_run(row_byte[wrle_pkg::CODE_SHIFT +: 2], run, total,
                            wrle_pkg::ST_OK, 1'b0);
                end
                total += run;
                row++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_run seen;
        t_run want;
        if (i_rst_n) begin
            // Results are taken first: a command accepted at this edge cannot cause one.
            if (i_runs.valid && i_runs.ready) begin
                seen.code   = i_runs.drive_code;
                seen.run    = i_runs.run_length;
                seen.phase  = i_runs.phase_start;
                seen.status = i_runs.status;
                seen.last   = i_runs.last;
                if (expected_runs.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected run: expected none, got code=%0d run=%0d",
                             $time, seen.code, seen.run,
                             " phase=%0d status=%0d last=%0d",
                             seen.phase, seen.status, seen.last);
                end else begin
                    want = expected_runs.pop_front();
                    if (seen !== want) begin
                        fail_total++;
                        $display("%0t: run mismatch: expected code=%0d run=%0d", $time,
                                 want.code, want.run,
                                 " phase=%0d status=%0d last=%0d,",
                                 want.phase, want.status, want.last,
                                 " got code=%0d run=%0d phase=%0d status=%0d last=%0d",
                                 seen.code, seen.run, seen.phase, seen.status, seen.last);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.action == 1'(wrle_pkg::K_WALK)) begin
                    expand_sequence(i_cmd.from_level, i_cmd.to_level, i_cmd.start_row);
                end else if (int'(i_cmd.load_address) < TABLE_DEPTH) begin
                    row_image[i_cmd.load_address] = i_cmd.load_byte;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_runs.size();
    end

endmodule

// ----- dv/waveform_run_length_expander_tb.sv -----
`timescale 1ns / 1ps
module waveform_run_length_expander_tb;

    localparam int TABLE_DEPTH = wrle_pkg::DEF_GRAY_LEVELS * wrle_pkg::DEF_GRAY_LEVELS
                               * wrle_pkg::DEF_ROWS_PER_SEQUENCE;
    localparam int ROWS = wrle_pkg::DEF_ROWS_PER_SEQUENCE;
    localparam int LEVEL_W = wrle_pkg::LEVEL_W;
    localparam int ROW_W = wrle_pkg::ROW_FIELD_W;
    localparam int ADDR_W = wrle_pkg::ADDR_W;
    localparam int BYTE_W = wrle_pkg::BYTE_W;
    localparam int COUNT_W = wrle_pkg::COUNT_W;
    localparam int STIMULUS_ITEMS = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {SEQ_SHORT, SEQ_FULL, SEQ_EMPTY, SEQ_TAIL} t_seq_shape;
    typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_PERIODIC} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_runs;
    int   idle_cycles;

    wrle_in_if  cmd_if ();
    wrle_out_if run_if ();

    waveform_run_length_expander DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (run_if)
    );

    wrle_run_checker u_run_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_runs       (run_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_runs)
    );

    always #1 i_clk = ~i_clk;

    // What the stimulus has written so far, so that no walk reads an unwritten row.
    logic [BYTE_W-1:0] row_img [TABLE_DEPTH];
    bit                row_known [TABLE_DEPTH];
    logic [ADDR_W-1:0] programmed_seqs [$];
    int                items_sent;
    int                programs_done;
    int                burst_left;

    t_rx_mode    rx_mode;
    int          rx_left;
    int unsigned rx_tick;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(4, 40);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_FREE:     run_if.ready <= 1'b1;
            RX_COIN:     run_if.ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY:   run_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: run_if.ready <= (rx_tick[2:0] < 3'd2);
            default:     run_if.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (run_if.valid && run_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[waveform_run_length_expander] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] seq_addr(input logic [LEVEL_W-1:0] f,
                                                   input logic [LEVEL_W-1:0] t,
                                                   input logic [ROW_W-1:0] row);
        return {f, t, row};
    endfunction

    function automatic logic [BYTE_W-1:0] random_row(input logic last);
        logic [COUNT_W-1:0] count;
        case ($urandom_range(0, 5))
            0:       count = '0;
            1:       count = '1;
            default: count = COUNT_W'($urandom);
        endcase
        return {2'($urandom), last, count};
    endfunction

    // True when a walk from this row only reads rows that have been written.
    function automatic bit walk_defined(input logic [LEVEL_W-1:0] f, input logic [LEVEL_W-1:0] t,
                                        input int first);
        logic [ADDR_W-1:0] a;
        bit                no_phases;
        no_phases = 1'b1;
        for (int r = first; r < ROWS; r++) begin
            a = seq_addr(f, t, ROW_W'(r));
            if (!row_known[a]) return 1'b0;
            if (row_img[a] == '0 && no_phases) return 1'b1;
            if (row_img[a][wrle_pkg::LAST_BIT]) return 1'b1;
            if (row_img[a][COUNT_W-1:0] != '0) no_phases = 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] data, input logic [LEVEL_W-1:0] from_l,
                             input logic [LEVEL_W-1:0] to_l,
                             input logic [ROW_W-1:0] row);
        int gap;
        cmd_if.valid        <= 1'b1;
        cmd_if.action       <= act;
        cmd_if.load_address <= addr;
        cmd_if.load_byte    <= data;
        cmd_if.from_level   <= from_l;
        cmd_if.to_level     <= to_l;
        cmd_if.start_row    <= row;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        items_sent++;
        if (act == 1'(wrle_pkg::K_LOAD)) begin
            row_img[addr]   = data;
            row_known[addr] = 1'b1;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 3);
            burst_left = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(0, 7);
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_row_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
        send_item(1'(wrle_pkg::K_LOAD), addr, data, LEVEL_W'($urandom), LEVEL_W'($urandom),
                  ROW_W'($urandom));
    endtask

    task automatic request_expand(input logic [LEVEL_W-1:0] f, input logic [LEVEL_W-1:0] t,
                                  input logic [ROW_W-1:0] row);
        send_item(1'(wrle_pkg::K_WALK), ADDR_W'($urandom), BYTE_W'($urandom), f, t, row);
    endtask

    // Holds the sender off until every queued run has come out.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_runs != 0) @(posedge i_clk);
    endtask

    task automatic program_sequence(input t_seq_shape shape);
        logic [LEVEL_W-1:0] f;
        logic [LEVEL_W-1:0] t;
        logic [BYTE_W-1:0]  data;
        int                 first;
        int                 len;
        bit                 closed;
        f      = LEVEL_W'($urandom);
        t      = LEVEL_W'($urandom);
        closed = 1'b1;
        case (shape)
            SEQ_FULL: begin
                first  = 0;
                len    = ROWS;
                closed = 1'($urandom_range(0, 1));
            end
            SEQ_EMPTY: begin
                first = $urandom_range(0, ROWS - 1);
                len   = 1;
            end
            SEQ_TAIL: begin
                first  = ROWS - 1 - $urandom_range(0, 4);
                len    = ROWS - first;
                closed = 1'($urandom_range(0, 1));
            end
            default: begin
                first = $urandom_range(0, ROWS - 1);
                len   = $urandom_range(1, 8);
                if (first + len >= ROWS) begin
                    len    = ROWS - first;
                    closed = 1'($urandom_range(0, 1));
                end
            end
        endcase
        for (int r = 0; r < len; r++) begin
            data = (shape == SEQ_EMPTY) ? '0 : random_row(closed && r == len - 1);
            load_row_byte(seq_addr(f, t, ROW_W'(first + r)), data);
        end
        programmed_seqs.push_back(seq_addr(f, t, ROW_W'(first)));
        programs_done++;
        if (walk_defined(f, t, first)) begin
            request_expand(f, t, ROW_W'(first));
        end
    endtask

    // Re-walks an earlier sequence, which noise loads may since have altered.
    task automatic replay_sequence();
        logic [ADDR_W-1:0]  entry;
        logic [LEVEL_W-1:0] f;
        logic [LEVEL_W-1:0] t;
        int                 first;
        if (programmed_seqs.size() == 0) return;
        entry = programmed_seqs[$urandom_range(0, programmed_seqs.size() - 1)];
        f     = entry[ADDR_W-1 -: LEVEL_W];
        t     = entry[ROW_W +: LEVEL_W];
        first = $urandom_range(int'(entry[ROW_W-1:0]), ROWS - 1);
        if (!walk_defined(f, t, first)) begin
            first = int'(entry[ROW_W-1:0]);
        end
        if (walk_defined(f, t, first)) begin
            request_expand(f, t, ROW_W'(first));
        end
    endtask

    initial begin
        int choice;
        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.action       = 1'b0;
        cmd_if.load_address = '0;
        cmd_if.load_byte    = '0;
        cmd_if.from_level   = '0;
        cmd_if.to_level     = '0;
        cmd_if.start_row    = '0;
        run_if.ready        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty sequence at the lowest address.
        load_row_byte(seq_addr(4'd0, 4'd0, 6'd0), 8'h00);
        request_expand(4'd0, 4'd0, 6'd0);
        // Runs off the final row without a last flag, up to the top address.
        load_row_byte(seq_addr(4'd15, 4'd15, 6'd61), 8'hDF);
        load_row_byte(seq_addr(4'd15, 4'd15, 6'd62), 8'h1F);
        load_row_byte(seq_addr(4'd15, 4'd15, 6'd63), 8'hC0);
        request_expand(4'd15, 4'd15, 6'd61);
        request_expand(4'd15, 4'd15, 6'd63);
        // A zero-count row first, so a zero row still counts as empty after it.
        load_row_byte(seq_addr(4'd5, 4'd10, 6'd0), 8'h40);
        load_row_byte(seq_addr(4'd5, 4'd10, 6'd1), 8'h00);
        request_expand(4'd5, 4'd10, 6'd0);
        // A zero row after some phases is an ordinary run of length zero.
        load_row_byte(seq_addr(4'd10, 4'd5, 6'd0), 8'h9F);
        load_row_byte(seq_addr(4'd10, 4'd5, 6'd1), 8'h00);
        load_row_byte(seq_addr(4'd10, 4'd5, 6'd2), 8'h25);
        request_expand(4'd10, 4'd5, 6'd0);
        load_row_byte(seq_addr(4'd3, 4'd12, 6'd63), 8'hFF);
        request_expand(4'd3, 4'd12, 6'd63);
        load_row_byte(seq_addr(4'd9, 4'd6, 6'd20), 8'h20);
        request_expand(4'd9, 4'd6, 6'd20);
        load_row_byte(seq_addr(4'd6, 4'd9, 6'd7), 8'h7E);
        request_expand(4'd6, 4'd9, 6'd7);
        drain_results();

        while (items_sent < STIMULUS_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (programs_done < 10) begin
                // Full-length walks come early, each closed or left open at random.
                program_sequence((programs_done == 8 || programs_done == 9) ? SEQ_FULL : SEQ_SHORT);
            end else if (choice < 10) begin
                load_row_byte(ADDR_W'($urandom), BYTE_W'($urandom));
            end else if (choice < 25) begin
                replay_sequence();
            end else if (choice < 28) begin
                drain_results();
            end else if (choice < 32) begin
                program_sequence(SEQ_EMPTY);
            end else if (choice < 37) begin
                program_sequence(SEQ_TAIL);
            end else if (choice < 39) begin
                program_sequence(SEQ_FULL);
            end else begin
                program_sequence(SEQ_SHORT);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[waveform_run_length_expander] OK");
        end else begin
            $display("[waveform_run_length_expander] ERROR");
        end
        $finish;
    end

endmodule
